>>> hw/rtl/ppu_pkg.sv
// Shared types and constants for the perspective projection unit.
`timescale 1ns / 1ps
package ppu_pkg;

    // Operation selector carried in the input tuser.
    typedef enum logic [1:0] {
        FUNC_COLUMN = 2'd0,
        FUNC_ANGLE  = 2'd1,
        FUNC_CLAMP  = 2'd2,
        FUNC_ROW    = 2'd3
    } t_func;

    // Configuration register indexes.
    localparam logic CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic CFG_SCREEN_HEIGHT = 1'b1;

    // Datapath widths.
    localparam int CORDIC_W     = 34;
    localparam int ANG_W        = 28;
    localparam int DIV_BITS     = 34;
    localparam int ATAN_ENTRIES = 24;

    typedef logic signed [CORDIC_W-1:0] t_cval;
    typedef logic signed [ANG_W-1:0]    t_ang;

    // Fixed-point constants.
    localparam t_ang PI_Q24      = 28'sd52707179;
    localparam t_ang HALF_PI_Q24 = 28'sd26353589;
    localparam logic signed [15:0] FOV_Q13 = 16'sd3146;
    localparam logic [16:0] INV_2TAN_Q16 = 17'd81104;
    localparam logic [17:0] ROW_SCALE    = 18'd256000;
    localparam logic [25:0] STEP_NUM     = 26'd65536000;
    localparam t_cval CORDIC_ONE         = 34'sd1073741824;
    localparam logic [12:0] RST_WIDTH_M1 = 13'd639;
    localparam logic [12:0] RST_HEIGHT   = 13'd480;

    // Arctangent of 2^-i in Q.24 radians.
    localparam t_ang ATAN_Q24 [ATAN_ENTRIES] = '{
        28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
        28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
        28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
        28'sd4096,     28'sd2048,    28'sd1024,    28'sd512,
        28'sd256,      28'sd128,     28'sd64,      28'sd32,
        28'sd16,       28'sd8,       28'sd4,       28'sd2
    };

    // Sideband that travels with each item down the cell chains.
    typedef struct packed {
        t_func              func;
        logic               spec;    // width of zero or one, zero atan2 input, or zero distance
        logic               neg;     // result sign before the magnitude divide
        logic               sat;     // column saturates
        logic               sat_lo;  // saturate toward the negative limit
        logic signed [15:0] ang;     // angle result for unproject and clamp
    } t_tag;

endpackage

>>> hw/rtl/ppu_cordic_cell.sv
// One CORDIC micro-rotation cell, rotation mode for columns, vectoring for angles.
`timescale 1ns / 1ps
module ppu_cordic_cell
    import ppu_pkg::*;
#(
    parameter int STAGE_IDX = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_ce,
    input  logic  i_valid,
    input  t_cval i_x,
    input  t_cval i_y,
    input  t_ang  i_z,
    input  t_tag  i_tag,
    output logic  o_valid,
    output t_cval o_x,
    output t_cval o_y,
    output t_ang  o_z,
    output t_tag  o_tag
);

    logic  r_valid;
    t_cval r_x, r_y;
    t_ang  r_z;
    t_tag  r_tag;

    t_cval xs, ys, n_x, n_y;
    t_ang  n_z;
    logic  pos;

    // Rotate toward zero angle, or toward zero y when vectoring.
    always_comb begin
        xs  = i_x >>> STAGE_IDX;
        ys  = i_y >>> STAGE_IDX;
        pos = (i_tag.func == FUNC_COLUMN) ? !i_z[ANG_W-1] : i_y[CORDIC_W-1];
        n_x = i_x;
        n_y = i_y;
        n_z = i_z;
        if (i_tag.func == FUNC_COLUMN || i_tag.func == FUNC_ANGLE) begin
            if (pos) begin
                n_x = i_x - ys;
                n_y = i_y + xs;
                n_z = i_z - ATAN_Q24[STAGE_IDX];
            end else begin
                n_x = i_x + ys;
                n_y = i_y - xs;
                n_z = i_z + ATAN_Q24[STAGE_IDX];
            end
        end
    end

    // Valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ce) begin
            r_valid <= i_valid;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_tag <= i_tag;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_tag   = r_tag;

endmodule

>>> hw/rtl/ppu_div_cell.sv
// One restoring-division cell: one quotient bit for each of two lanes sharing a divisor.
`timescale 1ns / 1ps
module ppu_div_cell
    import ppu_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_ce,
    input  logic                i_valid,
    input  logic [31:0]         i_div,
    input  logic [31:0]         i_rem_a,
    input  logic [DIV_BITS-1:0] i_acc_a,
    input  logic [31:0]         i_rem_b,
    input  logic [DIV_BITS-1:0] i_acc_b,
    input  t_tag                i_tag,
    output logic                o_valid,
    output logic [31:0]         o_div,
    output logic [31:0]         o_rem_a,
    output logic [DIV_BITS-1:0] o_acc_a,
    output logic [31:0]         o_rem_b,
    output logic [DIV_BITS-1:0] o_acc_b,
    output t_tag                o_tag
);

    logic                r_valid;
    logic [31:0]         r_div, r_rem_a, r_rem_b;
    logic [DIV_BITS-1:0] r_acc_a, r_acc_b;
    t_tag                r_tag;

    logic [32:0] trial_a, trial_b, diff_a, diff_b;
    logic        ge_a, ge_b;

    // Shift the next dividend bit into the remainder and try the subtract.
    // The accumulator loses dividend bits at the top and gains quotient bits at the bottom.
    always_comb begin
        trial_a = {i_rem_a, i_acc_a[DIV_BITS-1]};
        trial_b = {i_rem_b, i_acc_b[DIV_BITS-1]};
        diff_a  = trial_a - {1'b0, i_div};
        diff_b  = trial_b - {1'b0, i_div};
        ge_a    = trial_a >= {1'b0, i_div};
        ge_b    = trial_b >= {1'b0, i_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ce) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_div   <= i_div;
            r_rem_a <= ge_a ? diff_a[31:0] : trial_a[31:0];
            r_rem_b <= ge_b ? diff_b[31:0] : trial_b[31:0];
            r_acc_a <= {i_acc_a[DIV_BITS-2:0], ge_a};
            r_acc_b <= {i_acc_b[DIV_BITS-2:0], ge_b};
            r_tag   <= i_tag;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;
    assign o_rem_a = r_rem_a;
    assign o_acc_a = r_acc_a;
    assign o_rem_b = r_rem_b;
    assign o_acc_b = r_acc_b;
    assign o_tag   = r_tag;

endmodule

>>> hw/rtl/perspective_projection_unit_top.sv
// Perspective projection unit: setup stage, CORDIC cell chain, divider cell chain.
// Path from input transfer to result:
//   one setup stage, one CORDIC cell per stage, four scaling stages, 34 divider cells,
//   and the output register.
// Throughput: one item per cycle; the whole chain holds only while a result waits.
// Reset (i_rst_n low at a clock edge) empties the pipeline and sets width 640, height 480.
`timescale 1ns / 1ps
module perspective_projection_unit_top
    import ppu_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_idx,
    input  logic [12:0] i_cfg_data,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // view_angle, screen_x, height_z, distance
    input  logic [1:0]  s_axis_tuser,   // func
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // column_out, angle_out, row_top, row_step
    output logic        m_axis_tuser    // div_error
);

    // ------------------------------------------------------------------
    // Configuration registers.
    logic [12:0] r_width_m1;
    logic [12:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_m1 <= RST_WIDTH_M1;
            r_height   <= RST_HEIGHT;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_SCREEN_WIDTH: begin
                    r_width_m1 <= (i_cfg_data == 13'd0) ? 13'd0 : i_cfg_data - 13'd1;
                end
                CFG_SCREEN_HEIGHT: begin
                    r_height <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: everything advances unless a finished item is blocked.
    logic ce;
    logic tail_valid;
    logic r_out_valid;

    assign ce            = !(tail_valid && r_out_valid && !m_axis_tready);
    assign s_axis_tready = ce;

    // ------------------------------------------------------------------
    // Setup stage: load the CORDIC start vector for each operation.
    t_func              in_func;
    logic signed [15:0] in_va, in_sx, in_hz;
    logic [31:0]        in_dist;
    t_ang               red_a;
    t_cval              sx34, p1_x, p1_y;
    t_ang               p1_z;
    t_tag               p1_tag;
    logic [16:0]        hz_abs;
    logic [29:0]        xa;

    assign in_func = t_func'(s_axis_tuser);
    assign in_va   = s_axis_tdata[15:0];
    assign in_sx   = s_axis_tdata[31:16];
    assign in_hz   = s_axis_tdata[47:32];
    assign in_dist = s_axis_tdata[79:48];

    always_comb begin
        // Reduce the angle by pi where needed, since tan has period pi.
        red_a = ANG_W'(in_va) <<< 11;
        if (red_a > HALF_PI_Q24) begin
            red_a = red_a - PI_Q24;
        end else if (red_a < -HALF_PI_Q24) begin
            red_a = red_a + PI_Q24;
        end
        sx34   = CORDIC_W'(in_sx);
        hz_abs = in_hz[15] ? (17'd0 - 17'(in_hz)) : 17'(in_hz);
        xa     = 30'(r_width_m1) * 30'(INV_2TAN_Q16);

        p1_x   = '0;
        p1_y   = '0;
        p1_z   = '0;
        p1_tag = '{func: in_func, spec: 1'b0, neg: 1'b0, sat: 1'b0, sat_lo: 1'b0,
                   ang: 16'sd0};
        case (in_func)
            FUNC_COLUMN: begin
                p1_x        = CORDIC_ONE;
                p1_z        = red_a;
                p1_tag.spec = (r_width_m1 == 13'd0);
            end
            FUNC_ANGLE: begin
                p1_x        = CORDIC_W'(xa);
                p1_y        = $signed({6'd0, r_width_m1, 15'd0}) - (sx34 <<< 16);
                p1_tag.spec = (r_width_m1 == 13'd0) && (p1_y == '0);
            end
            FUNC_CLAMP: begin
                if (in_va > FOV_Q13) begin
                    p1_tag.ang = FOV_Q13;
                end else if (in_va < -FOV_Q13) begin
                    p1_tag.ang = -FOV_Q13;
                end else begin
                    p1_tag.ang = in_va;
                end
            end
            FUNC_ROW: begin
                p1_x        = $signed(CORDIC_W'(CORDIC_W'(hz_abs) * CORDIC_W'(ROW_SCALE)));
                p1_y        = $signed({2'd0, in_dist});
                p1_tag.spec = (in_dist == 32'd0);
                p1_tag.neg  = in_hz[15];
            end
            default: begin
            end
        endcase
    end

    t_cval w_cx [CORDIC_STAGES+1];
    t_cval w_cy [CORDIC_STAGES+1];
    t_ang  w_cz [CORDIC_STAGES+1];
    t_tag  w_ctag [CORDIC_STAGES+1];
    logic  w_cvalid [CORDIC_STAGES+1];

    logic  r_p1_valid;
    t_cval r_p1_x, r_p1_y;
    t_ang  r_p1_z;
    t_tag  r_p1_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (ce) begin
            r_p1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_p1_x   <= p1_x;
            r_p1_y   <= p1_y;
            r_p1_z   <= p1_z;
            r_p1_tag <= p1_tag;
        end
    end

    assign w_cvalid[0] = r_p1_valid;
    assign w_cx[0]     = r_p1_x;
    assign w_cy[0]     = r_p1_y;
    assign w_cz[0]     = r_p1_z;
    assign w_ctag[0]   = r_p1_tag;

    // ------------------------------------------------------------------
    // CORDIC cell chain.
    for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_cordic
        ppu_cordic_cell #(
            .STAGE_IDX(gi)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (ce),
            .i_valid (w_cvalid[gi]),
            .i_x     (w_cx[gi]),
            .i_y     (w_cy[gi]),
            .i_z     (w_cz[gi]),
            .i_tag   (w_ctag[gi]),
            .o_valid (w_cvalid[gi+1]),
            .o_x     (w_cx[gi+1]),
            .o_y     (w_cy[gi+1]),
            .o_z     (w_cz[gi+1]),
            .o_tag   (w_ctag[gi+1])
        );
    end

    // ------------------------------------------------------------------
    // Scaling stage 1: column saturation on a non-positive cosine, C*y,
    // and rounding of the unprojected angle.
    t_cval              c_x, c_y;
    t_ang               c_z, zr;
    t_tag               c_tag, q1_tag;
    logic signed [16:0] zs;

    assign c_x   = w_cx[CORDIC_STAGES];
    assign c_y   = w_cy[CORDIC_STAGES];
    assign c_z   = w_cz[CORDIC_STAGES];
    assign c_tag = w_ctag[CORDIC_STAGES];

    always_comb begin
        q1_tag = c_tag;
        zr     = c_z + 28'sd1024;
        zs     = 17'(zr >>> 11);
        if (c_tag.func == FUNC_COLUMN && !c_tag.spec && c_x <= t_cval'(0)) begin
            q1_tag.sat    = 1'b1;
            q1_tag.sat_lo = !c_y[CORDIC_W-1];
        end
        if (c_tag.func == FUNC_ANGLE) begin
            if (c_tag.spec) begin
                q1_tag.ang = 16'sd0;
            end else if (zs > 17'sd32767) begin
                q1_tag.ang = 16'sh7fff;
            end else if (zs < -17'sd32768) begin
                q1_tag.ang = 16'sh8000;
            end else begin
                q1_tag.ang = zs[15:0];
            end
        end
    end

    logic               r_q1_valid, r_q2_valid, r_q3_valid, r_q4_valid;
    t_cval              r_q1_x, r_q1_y, r_q2_x, r_q2_y, r_q3_x, r_q3_y;
    t_tag               r_q1_tag, r_q2_tag, r_q3_tag, r_q4_tag;
    logic signed [50:0] r_q1_prod;
    logic signed [49:0] r_q2_diff;
    logic signed [62:0] r_q3_num;
    t_tag               q3_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q1_valid <= 1'b0;
            r_q2_valid <= 1'b0;
            r_q3_valid <= 1'b0;
            r_q4_valid <= 1'b0;
        end else if (ce) begin
            r_q1_valid <= w_cvalid[CORDIC_STAGES];
            r_q2_valid <= r_q1_valid;
            r_q3_valid <= r_q2_valid;
            r_q4_valid <= r_q3_valid;
        end
    end

    // The column sign follows the sign of x*2^15 - C*y.
    always_comb begin
        q3_tag = r_q2_tag;
        if (r_q2_tag.func == FUNC_COLUMN) begin
            q3_tag.neg = r_q2_diff[49];
        end
    end

    // Scaling stages 1 to 3: C*y, then x*2^15 - C*y, then times (W-1).
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_q1_x    <= c_x;
            r_q1_y    <= c_y;
            r_q1_tag  <= q1_tag;
            r_q1_prod <= 51'(c_y) * $signed(51'(INV_2TAN_Q16));

            r_q2_x    <= r_q1_x;
            r_q2_y    <= r_q1_y;
            r_q2_tag  <= r_q1_tag;
            r_q2_diff <= (50'(r_q1_x) <<< 15) - 50'(r_q1_prod);

            r_q3_x    <= r_q2_x;
            r_q3_y    <= r_q2_y;
            r_q3_tag  <= q3_tag;
            r_q3_num  <= 63'(r_q2_diff) * $signed(63'({1'b0, r_width_m1}));
        end
    end

    // Scaling stage 4: magnitude over 2^16, huge-quotient check, divider load.
    logic [62:0] num_abs;
    logic [45:0] num_mag;
    t_tag        q4_tag;
    logic [31:0] q4_div, q4_rem_a;
    logic [DIV_BITS-1:0] q4_acc_a, q4_acc_b;

    always_comb begin
        num_abs  = r_q3_num[62] ? 63'(-r_q3_num) : 63'(r_q3_num);
        num_mag  = num_abs[61:16];
        q4_tag   = r_q3_tag;
        q4_div   = '0;
        q4_rem_a = '0;
        q4_acc_a = '0;
        q4_acc_b = '0;
        case (r_q3_tag.func)
            FUNC_COLUMN: begin
                q4_div   = r_q3_x[31:0];
                q4_rem_a = {20'd0, num_mag[45:34]};
                q4_acc_a = num_mag[33:0];
                if (!r_q3_tag.sat && ({20'd0, num_mag[45:34]} >= r_q3_x[31:0])) begin
                    q4_tag.sat    = 1'b1;
                    q4_tag.sat_lo = r_q3_tag.neg;
                end
            end
            FUNC_ROW: begin
                q4_div   = r_q3_y[31:0];
                q4_acc_a = r_q3_x[DIV_BITS-1:0];
                q4_acc_b = DIV_BITS'(STEP_NUM);
            end
            default: begin
            end
        endcase
    end

    logic [31:0]         r_q4_div, r_q4_rem_a;
    logic [DIV_BITS-1:0] r_q4_acc_a, r_q4_acc_b;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_q4_tag   <= q4_tag;
            r_q4_div   <= q4_div;
            r_q4_rem_a <= q4_rem_a;
            r_q4_acc_a <= q4_acc_a;
            r_q4_acc_b <= q4_acc_b;
        end
    end

    // ------------------------------------------------------------------
    // Divider cell chain.
    logic                w_dvalid [DIV_BITS+1];
    logic [31:0]         w_ddiv   [DIV_BITS+1];
    logic [31:0]         w_drem_a [DIV_BITS+1];
    logic [31:0]         w_drem_b [DIV_BITS+1];
    logic [DIV_BITS-1:0] w_dacc_a [DIV_BITS+1];
    logic [DIV_BITS-1:0] w_dacc_b [DIV_BITS+1];
    t_tag                w_dtag   [DIV_BITS+1];

    assign w_dvalid[0] = r_q4_valid;
    assign w_ddiv[0]   = r_q4_div;
    assign w_drem_a[0] = r_q4_rem_a;
    assign w_drem_b[0] = '0;
    assign w_dacc_a[0] = r_q4_acc_a;
    assign w_dacc_b[0] = r_q4_acc_b;
    assign w_dtag[0]   = r_q4_tag;

    for (genvar gd = 0; gd < DIV_BITS; gd++) begin : g_div
        ppu_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (ce),
            .i_valid (w_dvalid[gd]),
            .i_div   (w_ddiv[gd]),
            .i_rem_a (w_drem_a[gd]),
            .i_acc_a (w_dacc_a[gd]),
            .i_rem_b (w_drem_b[gd]),
            .i_acc_b (w_dacc_b[gd]),
            .i_tag   (w_dtag[gd]),
            .o_valid (w_dvalid[gd+1]),
            .o_div   (w_ddiv[gd+1]),
            .o_rem_a (w_drem_a[gd+1]),
            .o_acc_a (w_dacc_a[gd+1]),
            .o_rem_b (w_drem_b[gd+1]),
            .o_acc_b (w_dacc_b[gd+1]),
            .o_tag   (w_dtag[gd+1])
        );
    end

    assign tail_valid = w_dvalid[DIV_BITS];

    // ------------------------------------------------------------------
    // Result assembly: sign, saturation and the height offset.
    t_tag                res_tag;
    logic [DIV_BITS-1:0] qa, qb;
    logic signed [35:0]  top_w;
    logic signed [15:0]  n_col, n_ang;
    logic signed [31:0]  n_top, n_step;
    logic                n_err;

    always_comb begin
        res_tag = w_dtag[DIV_BITS];
        qa      = w_dacc_a[DIV_BITS];
        qb      = w_dacc_b[DIV_BITS];
        top_w   = (res_tag.neg ? $signed(36'(qa)) : -$signed(36'(qa)))
                  + $signed(36'({r_height, 7'd0}));
        n_col   = 16'sd0;
        n_ang   = 16'sd0;
        n_top   = 32'sd0;
        n_step  = 32'sd0;
        n_err   = 1'b0;
        case (res_tag.func)
            FUNC_COLUMN: begin
                if (res_tag.spec) begin
                    n_col = 16'sd0;
                end else if (res_tag.sat) begin
                    n_col = res_tag.sat_lo ? 16'sh8000 : 16'sh7fff;
                end else if (res_tag.neg) begin
                    n_col = (qa > DIV_BITS'(32768)) ? 16'sh8000 : -$signed(qa[15:0]);
                end else begin
                    n_col = (qa > DIV_BITS'(32767)) ? 16'sh7fff : $signed(qa[15:0]);
                end
            end
            FUNC_ANGLE, FUNC_CLAMP: begin
                n_ang = res_tag.ang;
            end
            FUNC_ROW: begin
                if (res_tag.spec) begin
                    n_err = 1'b1;
                end else begin
                    if (top_w > 36'sh07fffffff) begin
                        n_top = 32'sh7fffffff;
                    end else if (top_w < -36'sh080000000) begin
                        n_top = 32'sh80000000;
                    end else begin
                        n_top = top_w[31:0];
                    end
                    n_step = -$signed(qb[31:0]);
                end
            end
            default: begin
            end
        endcase
    end

    // Output register.
    logic [95:0] r_out_data;
    logic        r_out_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (tail_valid && ce) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tail_valid && ce) begin
            r_out_data <= {n_step, n_top, n_ang, n_col};
            r_out_err  <= n_err;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_err;

endmodule

>>> bench/perspective_projection_unit_top_tb.sv
// Self-checking testbench for the perspective projection unit: random and directed streams.
`timescale 1ns / 1ps
module perspective_projection_unit_top_tb;
    import ppu_pkg::*;

    localparam int STAGES = 16;
    localparam int LATENCY = STAGES + 40;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1750;
    localparam longint ATAN_TBL [24] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    typedef struct packed {
        t_func       func;
        logic [15:0] view_angle;
        logic [15:0] screen_x;
        logic [15:0] height_z;
        logic [31:0] distance;
    } t_item;

    typedef struct packed {
        logic [15:0] column_out;
        logic [15:0] angle_out;
        logic [31:0] row_top;
        logic [31:0] row_step;
        logic        div_error;
    } t_proj;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic        i_cfg_idx;
    logic [12:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;
    logic        m_axis_tuser;

    perspective_projection_unit_top #(.CORDIC_STAGES(STAGES)) u_top (.*);

    // Bench copy of the configuration registers.
    longint model_width;
    longint model_height;

    t_item  pending_items[$];
    t_proj  expected_proj[$];
    int     send_idle_pct;
    int     recv_idle_pct;
    bit     hold_send;
    int     mismatches;
    int     quiet_cycles;
    bit     stim_done;
    bit     in_accepted;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Angle to column through a rotation CORDIC.
    function automatic longint column_of_angle(longint ang13);
        longint a, x, y, xs, ys, w1, num;
        a = ang13 * 2048;
        x = 64'sd1 << 30;
        y = 0;
        if (a > 26353589) a -= 52707179;
        else if (a < -26353589) a += 52707179;
        for (int i = 0; i < STAGES; i++) begin
            xs = floor_shr(x, i);
            ys = floor_shr(y, i);
            if (a >= 0) begin
                x -= ys; y += xs; a -= ATAN_TBL[i];
            end else begin
                x += ys; y -= xs; a += ATAN_TBL[i];
            end
        end
        w1 = (model_width == 0) ? 0 : model_width - 1;
        if (w1 == 0) return 0;
        if (x <= 0) return (y >= 0) ? -32768 : 32767;
        num = w1 * (x * 32768 - 81104 * y);
        return clip(num / (x * 65536), -32768, 32767);
    endfunction

    // Column to angle through a vectoring CORDIC.
    function automatic longint angle_of_column(longint sx);
        longint w1, x, y, z, xs, ys;
        w1 = (model_width == 0) ? 0 : model_width - 1;
        x = w1 * 81104;
        y = w1 * 32768 - sx * 65536;
        z = 0;
        if (x == 0 && y == 0) return 0;
        for (int i = 0; i < STAGES; i++) begin
            xs = floor_shr(x, i);
            ys = floor_shr(y, i);
            if (y >= 0) begin
                x += ys; y -= xs; z += ATAN_TBL[i];
            end else begin
                x -= ys; y += xs; z -= ATAN_TBL[i];
            end
        end
        return clip(floor_shr(z + 1024, 11), -32768, 32767);
    endfunction

    function automatic t_proj project_item(t_item it);
        t_proj  r;
        longint z, q, top;
        longint unsigned d, mag;
        r = '0;
        case (it.func)
            FUNC_COLUMN: r.column_out = 16'(column_of_angle(longint'($signed(it.view_angle))));
            FUNC_ANGLE:  r.angle_out = 16'(angle_of_column(longint'($signed(it.screen_x))));
            FUNC_CLAMP:  r.angle_out =
                16'(clip(longint'($signed(it.view_angle)), -3146, 3146));
            default: begin
                z = longint'($signed(it.height_z));
                d = it.distance;
                if (d == 0) begin
                    r.div_error = 1'b1;
                end else begin
                    mag = longint'(z < 0 ? -z : z) * 256000;
                    q = longint'(mag / d);
                    top = ((z < 0) ? q : -q) + model_height * 128;
                    r.row_top = 32'(clip(top, -64'sd2147483648, 64'sd2147483647));
                    r.row_step = 32'(-longint'(64'd65536000 / d));
                end
            end
        endcase
        return r;
    endfunction

    // Driver: presents items from the pending queue at the falling edge.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!s_axis_tvalid || in_accepted) begin
                if (pending_items.size() > 0 && !hold_send &&
                    $urandom_range(99) >= send_idle_pct) begin
                    t_item it;
                    it = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= it.func;
                    s_axis_tdata <= {it.distance, it.height_z, it.screen_x, it.view_angle};
                    expected_proj.push_back(project_item(it));
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: compares each result transfer with the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
            in_accepted <= 1'b0;
        end else begin
            in_accepted <= s_axis_tvalid && s_axis_tready;
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (m_axis_tvalid && m_axis_tready) begin
                t_proj got, want;
                got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[63:32],
                       m_axis_tdata[95:64], m_axis_tuser};
                if (expected_proj.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("Unexpected result %h", got);
                end else begin
                    want = expected_proj.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"Mismatch: col %h/%h ang %h/%h top %h/%h ",
                                      "step %h/%h err %b/%b"},
                                     want.column_out, got.column_out, want.angle_out,
                                     got.angle_out, want.row_top, got.row_top,
                                     want.row_step, got.row_step, want.div_error,
                                     got.div_error);
                    end
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic t_item random_item();
        t_item it;
        it.func = t_func'($urandom_range(3));
        it.view_angle = 16'($signed($urandom_range(51472)) - 25736);
        if ($urandom_range(3) == 0) it.view_angle = 16'($signed($urandom_range(6400)) - 3200);
        it.screen_x = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(4200));
        it.height_z = 16'($urandom);
        case ($urandom_range(3))
            0: it.distance = $urandom;
            1: it.distance = $urandom_range(300);
            2: it.distance = $urandom_range(70000);
            default: it.distance = $urandom_range(1);
        endcase
        return it;
    endfunction

    function automatic t_item make_item(t_func f, int ang, int sx, int hz, longint unsigned d);
        t_item it;
        it.func = f;
        it.view_angle = 16'(ang);
        it.screen_x = 16'(sx);
        it.height_z = 16'(hz);
        it.distance = 32'(d);
        return it;
    endfunction

    task automatic write_reg(logic idx, int value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= 13'(value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == CFG_SCREEN_WIDTH) model_width = value;
        else model_height = value;
    endtask

    // Waits until the pipeline is empty and every prediction has been met.
    task automatic drain();
        while (pending_items.size() > 0 || expected_proj.size() > 0 || s_axis_tvalid)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic run_random(int count);
        for (int i = 0; i < count; i++) pending_items.push_back(random_item());
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_idx = CFG_SCREEN_WIDTH;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = FUNC_COLUMN;
        m_axis_tready = 1'b0;
        model_width = 640;
        model_height = 480;
        send_idle_pct = 22;
        recv_idle_pct = 55;
        hold_send = 1'b0;
        mismatches = 0;
        stim_done = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes of every operation at the reset setting.
        pending_items.push_back(make_item(FUNC_COLUMN, 0, 0, 0, 1));
        pending_items.push_back(make_item(FUNC_COLUMN, 25736, 0, 0, 1));
        pending_items.push_back(make_item(FUNC_COLUMN, -25736, 0, 0, 1));
        pending_items.push_back(make_item(FUNC_COLUMN, 12868, 0, 0, 1));
        pending_items.push_back(make_item(FUNC_COLUMN, -12868, 0, 0, 1));
        pending_items.push_back(make_item(FUNC_COLUMN, 3146, 0, 0, 1));
        pending_items.push_back(make_item(FUNC_ANGLE, 0, -32768, 0, 1));
        pending_items.push_back(make_item(FUNC_ANGLE, 0, 32767, 0, 1));
        pending_items.push_back(make_item(FUNC_ANGLE, 0, 0, 0, 1));
        pending_items.push_back(make_item(FUNC_ANGLE, 0, 639, 0, 1));
        pending_items.push_back(make_item(FUNC_CLAMP, 25736, 0, 0, 1));
        pending_items.push_back(make_item(FUNC_CLAMP, -25736, 0, 0, 1));
        pending_items.push_back(make_item(FUNC_CLAMP, 3000, 0, 0, 1));
        pending_items.push_back(make_item(FUNC_ROW, 0, 0, 32767, 0));
        pending_items.push_back(make_item(FUNC_ROW, 0, 0, -32768, 1));
        pending_items.push_back(make_item(FUNC_ROW, 0, 0, 32767, 1));
        pending_items.push_back(make_item(FUNC_ROW, 0, 0, 0, 7));
        pending_items.push_back(make_item(FUNC_ROW, -1, -1, -1, 32'hFFFF_FFFF));
        run_random(500);
        drain();

        // Extreme registers: smallest width, tallest screen, zero width.
        write_reg(CFG_SCREEN_WIDTH, 2);
        write_reg(CFG_SCREEN_HEIGHT, 4096);
        run_random(200);
        drain();
        write_reg(CFG_SCREEN_WIDTH, 0);
        write_reg(CFG_SCREEN_HEIGHT, 8191);
        pending_items.push_back(make_item(FUNC_ANGLE, 0, 0, 0, 1));
        pending_items.push_back(make_item(FUNC_COLUMN, 1000, 0, 0, 1));
        run_random(100);
        drain();

        // Swap idling roles, width 4096 and height 1; the sender pauses once mid-phase.
        send_idle_pct = 55;
        recv_idle_pct = 22;
        write_reg(CFG_SCREEN_WIDTH, 4096);
        write_reg(CFG_SCREEN_HEIGHT, 1);
        run_random(250);
        while (pending_items.size() > 125) @(posedge i_clk);
        hold_send = 1'b1;
        while (expected_proj.size() > 0 || s_axis_tvalid) @(posedge i_clk);
        hold_send = 1'b0;
        run_random(200);
        drain();

        // No idling on either side, random setting.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_SCREEN_WIDTH, $urandom_range(2, 8191));
        write_reg(CFG_SCREEN_HEIGHT, $urandom_range(1, 8191));
        run_random(500);
        drain();

        if (mismatches == 0 && expected_proj.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
